### src/wca_pkg.sv
package wca_pkg;

  // Default sizes of the wheel store.
  localparam int WHEELS_DEF  = 32;
  localparam int LETTERS_DEF = 26;

  // Cylinder slots and the depth of the command queue.
  localparam int SLOTS       = 32;
  localparam int QUEUE_DEPTH = 2;

  // Field widths of one item.
  localparam int KIND_W   = 2;
  localparam int INDEX_W  = 5;
  localparam int LETTER_W = 8;
  localparam int STEPS_W  = 5;

  // Request kinds.
  typedef enum logic [KIND_W-1:0] {
    REQ_LOAD  = 2'd0,
    REQ_SET   = 2'd1,
    REQ_ALIGN = 2'd2,
    REQ_READ  = 2'd3
  } req_kind_t;

  // Back end sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_SEARCH
  } back_state_t;

  // A classified request as it waits in the queue.
  typedef struct packed {
    req_kind_t             kind;
    logic [INDEX_W-1:0]    wheel_index;
    logic [INDEX_W-1:0]    slot;
    logic [INDEX_W-1:0]    position;
    logic [LETTER_W-1:0]   letter;
    logic                  wheel_ok;
    logic                  pos_ok;
  } cmd_t;

  // Queue head as seen by the back end.
  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } queue_head_t;

endpackage

### src/wca_front.sv
module wca_front import wca_pkg::*; #(
  parameter int WHEELS  = WHEELS_DEF,
  parameter int LETTERS = LETTERS_DEF
) (
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [KIND_W-1:0]     s_tuser,
  input  logic [23:0]           s_tdata,
  input  logic                  q_full,
  output logic                  push,
  output cmd_t                  push_cmd
);

  localparam logic [6:0] WHEELS_W  = 7'(WHEELS);
  localparam logic [6:0] LETTERS_W = 7'(LETTERS);

  // Items are taken whenever the queue has room.
  assign s_tready = !q_full;
  assign push     = s_tvalid && !q_full;

  // Unpack the item and mark which indexes are in range.
  always_comb begin
    push_cmd.kind        = req_kind_t'(s_tuser);
    push_cmd.wheel_index = s_tdata[4:0];
    push_cmd.slot        = s_tdata[9:5];
    push_cmd.position    = s_tdata[14:10];
    push_cmd.letter      = s_tdata[22:15];
    push_cmd.wheel_ok    = {2'b00, s_tdata[4:0]} < WHEELS_W;
    push_cmd.pos_ok      = {2'b00, s_tdata[14:10]} < LETTERS_W;
  end

endmodule

### src/wca_queue.sv
module wca_queue import wca_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  cmd_t        push_cmd,
  output logic        full,
  input  logic        pop,
  output queue_head_t head
);

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  cmd_t          entries [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign full       = count == CW'(QUEUE_DEPTH);
  assign head.valid = count != '0;
  assign head.cmd   = entries[rd_ptr];

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

### src/wca_back.sv
module wca_back import wca_pkg::*; #(
  parameter int WHEELS  = WHEELS_DEF,
  parameter int LETTERS = LETTERS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  queue_head_t         head,
  output logic                pop,
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [KIND_W-1:0]   m_tuser,
  output logic [15:0]         m_tdata
);

  localparam int DEPTH = WHEELS * LETTERS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int OW    = $clog2(LETTERS);
  localparam int CW    = $clog2(LETTERS + 1);
  localparam int SW    = ((OW > INDEX_W) ? OW : INDEX_W) + 1;
  localparam int SIW   = $clog2(SLOTS);
  localparam logic [6:0] WHEELS_W = 7'(WHEELS);

  // Wheel letter store.
  logic [LETTER_W-1:0] mem [DEPTH];
  logic [LETTER_W-1:0] rd_data;

  // Slot tables.
  logic [INDEX_W-1:0] slot_wheel  [SLOTS];
  logic [OW-1:0]      slot_offset [SLOTS];

  // Sequencer state and working registers.
  back_state_t         state;
  back_state_t         state_next;
  req_kind_t           cur_kind;
  logic [SIW-1:0]      cur_slot;
  logic [LETTER_W-1:0] cur_letter;
  logic [AW-1:0]       base;
  logic [OW-1:0]       cur_pos;
  logic [CW-1:0]       issue_cnt;
  logic                pending;
  logic [OW-1:0]       pend_j;
  logic [OW-1:0]       pend_pos;

  // Result register.
  logic                out_valid;
  req_kind_t           out_kind;
  logic                out_found;
  logic [STEPS_W-1:0]  out_steps;
  logic [LETTER_W-1:0] out_letter;

  // Control decoded from the state.
  logic                mem_we;
  logic [AW-1:0]       wr_addr;
  logic                rd_en;
  logic [AW-1:0]       rd_addr;
  logic                res_load;
  logic                res_found;
  logic [STEPS_W-1:0]  res_steps;
  logic [LETTER_W-1:0] res_letter;
  logic                set_wr;
  logic                hit_wr;
  logic                search_start;
  logic                issue;
  logic                hit;
  logic                miss_end;

  // Lookups for the queue head.
  logic [INDEX_W-1:0] h_wheel;
  logic [OW-1:0]      h_off;
  logic               h_wheel_ok;
  logic [AW-1:0]      h_base;
  logic [SW-1:0]      h_sum;
  logic [OW-1:0]      h_row_pos;
  logic [SIW-1:0]     h_slot;

  assign h_slot     = head.cmd.slot;
  assign h_wheel    = slot_wheel[h_slot];
  assign h_off      = slot_offset[h_slot];
  assign h_wheel_ok = {2'b00, h_wheel} < WHEELS_W;
  assign h_base     = AW'(int'(h_wheel) * LETTERS);

  // Row position of a read, wrapped once around the ring.
  always_comb begin
    h_sum = SW'(h_off) + SW'(head.cmd.position);
    if (h_sum >= SW'(LETTERS)) begin
      h_sum = h_sum - SW'(LETTERS);
    end
    h_row_pos = OW'(h_sum);
  end

  // Search compare on the letter returned by the store.
  assign hit      = pending && (rd_data == cur_letter);
  assign miss_end = pending && !hit && (pend_j == OW'(LETTERS - 1));
  assign issue    = (state == ST_SEARCH) && (issue_cnt < CW'(LETTERS)) && !hit;

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (pop && head.cmd.kind == REQ_READ && head.cmd.pos_ok && h_wheel_ok) begin
          state_next = ST_READ;
        end else if (pop && head.cmd.kind == REQ_ALIGN && h_wheel_ok) begin
          state_next = ST_SEARCH;
        end
      end
      ST_READ: begin
        state_next = ST_IDLE;
      end
      ST_SEARCH: begin
        if (hit || miss_end) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Control outputs.
  always_comb begin
    pop          = 1'b0;
    mem_we       = 1'b0;
    wr_addr      = AW'(int'(head.cmd.wheel_index) * LETTERS + int'(head.cmd.position));
    rd_en        = 1'b0;
    rd_addr      = base + AW'(cur_pos);
    res_load     = 1'b0;
    res_found    = 1'b1;
    res_steps    = '0;
    res_letter   = '0;
    set_wr       = 1'b0;
    hit_wr       = 1'b0;
    search_start = 1'b0;
    unique case (state)
      ST_IDLE: begin
        pop = head.valid && !out_valid;
        if (pop) begin
          unique case (head.cmd.kind)
            REQ_LOAD: begin
              mem_we   = head.cmd.wheel_ok && head.cmd.pos_ok;
              res_load = 1'b1;
            end
            REQ_SET: begin
              set_wr   = head.cmd.wheel_ok;
              res_load = 1'b1;
            end
            REQ_ALIGN: begin
              if (h_wheel_ok) begin
                search_start = 1'b1;
              end else begin
                res_load  = 1'b1;
                res_found = 1'b0;
              end
            end
            REQ_READ: begin
              if (head.cmd.pos_ok && h_wheel_ok) begin
                rd_en   = 1'b1;
                rd_addr = h_base + AW'(h_row_pos);
              end else begin
                res_load = 1'b1;
              end
            end
            default: begin
              res_load = 1'b1;
            end
          endcase
        end
      end
      ST_READ: begin
        res_load   = 1'b1;
        res_letter = rd_data;
      end
      ST_SEARCH: begin
        rd_en = issue;
        if (hit) begin
          res_load  = 1'b1;
          res_steps = STEPS_W'(pend_j);
          hit_wr    = 1'b1;
        end else if (miss_end) begin
          res_load  = 1'b1;
          res_found = 1'b0;
        end
      end
      default: begin
        pop = 1'b0;
      end
    endcase
  end

  // Letter store: one write port and one registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= head.cmd.letter;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  // Slot tables: identity order and zero offsets after reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < SLOTS; i++) begin
        slot_wheel[i]  <= INDEX_W'(i);
        slot_offset[i] <= '0;
      end
    end else begin
      if (set_wr) begin
        slot_wheel[h_slot]  <= head.cmd.wheel_index;
        slot_offset[h_slot] <= '0;
      end else if (hit_wr) begin
        slot_offset[cur_slot] <= pend_pos;
      end
    end
  end

  // Sequencer control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      pending   <= 1'b0;
      issue_cnt <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (search_start) begin
        pending   <= 1'b0;
        issue_cnt <= '0;
      end else if (state == ST_SEARCH) begin
        pending <= issue;
        if (issue) begin
          issue_cnt <= issue_cnt + 1'b1;
        end
      end else begin
        pending <= 1'b0;
      end
      if (res_load) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Working payload of the current request.
  always_ff @(posedge clk) begin
    if (pop) begin
      cur_kind   <= head.cmd.kind;
      cur_slot   <= h_slot;
      cur_letter <= head.cmd.letter;
      base       <= h_base;
      cur_pos    <= h_off;
    end else if (issue) begin
      cur_pos <= (cur_pos == OW'(LETTERS - 1)) ? '0 : cur_pos + 1'b1;
    end
    if (issue) begin
      pend_j   <= OW'(issue_cnt);
      pend_pos <= cur_pos;
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (res_load) begin
      out_kind   <= (state == ST_IDLE) ? head.cmd.kind : cur_kind;
      out_found  <= res_found;
      out_steps  <= res_steps;
      out_letter <= res_letter;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tuser  = out_kind;
  assign m_tdata  = {2'b00, out_letter, out_steps, out_found};

endmodule

### src/wheel_cipher_aligner.sv
// A load, a set, a row past the wheel or an absent wheel is answered straight from the queue
// head; a read passes through the registered read port of the wheel store, and an align runs
// a one-letter-per-cycle search over that read port until a hit or the end of the wheel.
// The back end takes a new item only when idle and once the last result has been taken.
// Synchronous active-high reset empties the queue, sets slot i to wheel i with zero
// offset; the letter store is not cleared and holds no value until loaded.
module wheel_cipher_aligner import wca_pkg::*; #(
  parameter int WHEELS  = WHEELS_DEF,
  parameter int LETTERS = LETTERS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  // req_type
  input  logic [KIND_W-1:0] s_tuser,
  // wheel_index [4:0], slot [9:5], position [14:10], letter [22:15], zero [23]
  input  logic [23:0]       s_tdata,
  output logic              m_tvalid,
  input  logic              m_tready,
  // kind_done
  output logic [KIND_W-1:0] m_tuser,
  // found [0], steps [5:1], letter_out [13:6], zero [15:14]
  output logic [15:0]       m_tdata
);

  logic        q_full;
  logic        push;
  cmd_t        push_cmd;
  logic        pop;
  queue_head_t head;

  // Front end: takes and classifies items.
  wca_front #(
    .WHEELS  (WHEELS),
    .LETTERS (LETTERS)
  ) u_front (
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .s_tdata  (s_tdata),
    .q_full   (q_full),
    .push     (push),
    .push_cmd (push_cmd)
  );

  // Command queue between the two halves.
  wca_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (pop),
    .head     (head)
  );

  // Back end: store, slot tables, search and result register.
  wca_back #(
    .WHEELS  (WHEELS),
    .LETTERS (LETTERS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .head     (head),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tuser  (m_tuser),
    .m_tdata  (m_tdata)
  );

endmodule

### dv/wheel_cipher_aligner_tb.sv
`timescale 1ns / 1ps

module wheel_cipher_aligner_tb;
  import wca_pkg::*;

  localparam int WHEELS         = WHEELS_DEF;
  localparam int LETTERS        = LETTERS_DEF;
  localparam int RANDOM_ITEMS   = 1600;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int REPORT_LIMIT   = 10;

  // One request item and one answer item, in the block's own widths.
  typedef struct packed {
    req_kind_t           kind;
    logic [INDEX_W-1:0]  wheel_index;
    logic [INDEX_W-1:0]  slot;
    logic [INDEX_W-1:0]  position;
    logic [LETTER_W-1:0] letter;
  } wheel_req_t;

  typedef struct packed {
    logic [KIND_W-1:0]   kind_done;
    logic                found;
    logic [STEPS_W-1:0]  steps;
    logic [LETTER_W-1:0] letter_out;
  } wheel_answer_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              s_tvalid = 1'b0;
  logic              s_tready;
  logic [KIND_W-1:0] s_tuser = '0;
  logic [23:0]       s_tdata = '0;
  logic              m_tvalid;
  logic              m_tready = 1'b0;
  logic [KIND_W-1:0] m_tuser;
  logic [15:0]       m_tdata;

  // Shadow of the cylinder, advanced as requests are queued.
  logic [LETTER_W-1:0] wheel_store  [WHEELS*LETTERS];
  bit                  store_loaded [WHEELS*LETTERS];
  logic [INDEX_W-1:0]  wheel_of_slot  [SLOTS];
  logic [INDEX_W-1:0]  offset_of_slot [SLOTS];

  wheel_req_t    queued_requests [$];
  wheel_answer_t queued_answers  [$];
  wheel_answer_t awaited_answers [$];
  wheel_answer_t answer_in_flight;

  bit req_busy = 1'b0;
  int send_gap = 0;
  int send_calm = 0;
  int recv_stall = 0;
  int recv_calm = 0;
  int fail_count = 0;
  int answer_count = 0;
  int idle_cycles = 0;
  int items_queued = 0;

  wheel_cipher_aligner #(
    .WHEELS  (WHEELS),
    .LETTERS (LETTERS)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tuser  (m_tuser),
    .m_tdata  (m_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Store entry shown at a row of the rotated wheel in a slot.
  function automatic int entry_of(logic [INDEX_W-1:0] s, int row);
    return int'(wheel_of_slot[s]) * LETTERS +
           ((int'(offset_of_slot[s]) % LETTERS + row) % LETTERS);
  endfunction

  // Advances the shadow cylinder by one request and returns its answer.
  function automatic wheel_answer_t predict_answer(wheel_req_t r);
    wheel_answer_t ans;
    int hit_row;
    ans.kind_done  = r.kind;
    ans.found      = 1'b1;
    ans.steps      = '0;
    ans.letter_out = '0;
    hit_row        = -1;
    case (r.kind)
      REQ_LOAD: begin
        if (r.wheel_index < WHEELS && r.position < LETTERS) begin
          wheel_store[r.wheel_index * LETTERS + r.position]  = r.letter;
          store_loaded[r.wheel_index * LETTERS + r.position] = 1'b1;
        end
      end
      REQ_SET: begin
        if (r.wheel_index < WHEELS) begin
          wheel_of_slot[r.slot]  = r.wheel_index;
          offset_of_slot[r.slot] = '0;
        end
      end
      REQ_ALIGN: begin
        // The first matching row wins; a miss leaves the wheel where it is.
        ans.found = 1'b0;
        if (wheel_of_slot[r.slot] < WHEELS) begin
          for (int j = 0; j < LETTERS; j++) begin
            if (hit_row < 0 && wheel_store[entry_of(r.slot, j)] == r.letter) hit_row = j;
          end
          if (hit_row >= 0) begin
            ans.found = 1'b1;
            ans.steps = STEPS_W'(hit_row);
            offset_of_slot[r.slot] =
              INDEX_W'((int'(offset_of_slot[r.slot]) % LETTERS + hit_row) % LETTERS);
          end
        end
      end
      default: begin
        if (r.position < LETTERS && wheel_of_slot[r.slot] < WHEELS) begin
          ans.letter_out = wheel_store[entry_of(r.slot, r.position)];
        end
      end
    endcase
    return ans;
  endfunction

  // First never-loaded entry that a request would look at, or -1 if none.
  function automatic int first_gap(wheel_req_t r);
    int e;
    if (wheel_of_slot[r.slot] >= WHEELS) return -1;
    if (r.kind == REQ_ALIGN) begin
      for (int j = 0; j < LETTERS; j++) begin
        e = entry_of(r.slot, j);
        if (!store_loaded[e]) return e;
        if (wheel_store[e] == r.letter) return -1;
      end
    end else if (r.kind == REQ_READ && r.position < LETTERS) begin
      e = entry_of(r.slot, r.position);
      if (!store_loaded[e]) return e;
    end
    return -1;
  endfunction

  function automatic wheel_req_t make_req(req_kind_t kind, int wheel, int s, int pos,
                                          int ltr);
    wheel_req_t r;
    r.kind        = kind;
    r.wheel_index = INDEX_W'(wheel);
    r.slot        = INDEX_W'(s);
    r.position    = INDEX_W'(pos);
    r.letter      = LETTER_W'(ltr);
    return r;
  endfunction

  function automatic wheel_req_t random_req();
    return make_req(req_kind_t'($urandom_range(0, 3)), $urandom_range(0, 31),
                    $urandom_range(0, 31), $urandom_range(0, 31), $urandom_range(0, 255));
  endfunction

  // Up to half are letters that sit on the slot's wheel, some from a narrow alphabet.
  function automatic logic [LETTER_W-1:0] pick_align_letter(logic [INDEX_W-1:0] s);
    int roll;
    int e;
    roll = $urandom_range(0, 9);
    if (roll < 5 && wheel_of_slot[s] < WHEELS) begin
      e = entry_of(s, $urandom_range(0, LETTERS - 1));
      if (store_loaded[e]) return wheel_store[e];
    end
    if (roll < 7) return 8'h41 + LETTER_W'($urandom_range(0, 7));
    return LETTER_W'($urandom_range(0, 255));
  endfunction

  // Idle length for either side: mostly short, a few long, with calm stretches.
  function automatic int pick_gap(inout int calm);
    int roll;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    roll = $urandom_range(0, 99);
    if (roll < 3) begin
      calm = $urandom_range(20, 80);
      return 0;
    end
    if (roll < 60) return 0;
    if (roll < 88) return $urandom_range(1, 2);
    if (roll < 97) return $urandom_range(3, 10);
    return $urandom_range(20, 60);
  endfunction

  // Queues a request, loading first any entry it would look at unloaded.
  task automatic push_req(wheel_req_t r);
    wheel_req_t fill;
    int gap;
    gap = first_gap(r);
    while (gap >= 0) begin
      fill = make_req(REQ_LOAD, gap / LETTERS, $urandom_range(0, 31), gap % LETTERS,
                      $urandom_range(0, 255));
      queued_requests.push_back(fill);
      queued_answers.push_back(predict_answer(fill));
      items_queued++;
      gap = first_gap(r);
    end
    queued_requests.push_back(r);
    queued_answers.push_back(predict_answer(r));
    items_queued++;
  endtask

  // Holds the sender back until every queued item has been answered.
  task automatic wait_drained();
    while (queued_requests.size() != 0 || req_busy || awaited_answers.size() != 0)
      @(posedge clk);
  endtask

  // Driver: presents the next queued request after the chosen gap.
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!req_busy) begin
      if (send_gap > 0) begin
        send_gap--;
        s_tvalid <= 1'b0;
      end else if (queued_requests.size() != 0) begin
        wheel_req_t r;
        r                = queued_requests.pop_front();
        answer_in_flight = queued_answers.pop_front();
        s_tuser  <= r.kind;
        s_tdata  <= {1'b0, r.letter, r.position, r.slot, r.wheel_index};
        s_tvalid <= 1'b1;
        req_busy = 1'b1;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: random back pressure on the answer side.
  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (recv_stall > 0) begin
      recv_stall--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
      recv_stall = pick_gap(recv_calm);
    end
  end

  // Monitor: records accepted requests and checks each answer in order.
  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        awaited_answers.push_back(answer_in_flight);
        req_busy = 1'b0;
        send_gap = pick_gap(send_calm);
      end
      if (m_tvalid && m_tready) begin
        wheel_answer_t got;
        wheel_answer_t want;
        got.kind_done  = m_tuser;
        got.found      = m_tdata[0];
        got.steps      = m_tdata[5:1];
        got.letter_out = m_tdata[13:6];
        if (awaited_answers.size() == 0) begin
          fail_count++;
          if (fail_count <= REPORT_LIMIT)
            $display("answer %0d arrived with none awaited: kind %0d data %h",
                     answer_count, m_tuser, m_tdata);
        end else begin
          want = awaited_answers.pop_front();
          if (got !== want) begin
            fail_count++;
            if (fail_count <= REPORT_LIMIT)
              $display("answer %0d: want %0d/%0b/%0d/%h got %0d/%0b/%0d/%h",
                       answer_count, want.kind_done, want.found, want.steps, want.letter_out,
                       got.kind_done, got.found, got.steps, got.letter_out);
          end
        end
        answer_count++;
      end
    end
  end

  // Watchdog: ends the run when neither side has moved an item for too long.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int start;
    int sel;
    int narrow;
    bit paused;
    logic [INDEX_W-1:0] s;
    logic [LETTER_W-1:0] ltr;

    paused = 1'b0;
    for (int i = 0; i < SLOTS; i++) begin
      wheel_of_slot[i]  = INDEX_W'(i);
      offset_of_slot[i] = '0;
    end

    // Directed: wheel 1 gets distinct letters with both extreme bytes on it.
    for (int p = 0; p < LETTERS; p++) begin
      ltr = (p == 0) ? 8'h00 : (p == LETTERS - 1) ? 8'hFF : LETTER_W'(p * 9 + 1);
      push_req(make_req(REQ_LOAD, 1, $urandom_range(0, 31), p, int'(ltr)));
    end
    // A position past the wheel is dropped.
    push_req(make_req(REQ_LOAD, 1, 0, 31, 8'hAA));
    push_req(make_req(REQ_LOAD, 31, 31, 0, 8'h5A));
    push_req(make_req(REQ_SET, 1, 0, 0, 8'h00));
    push_req(make_req(REQ_READ, 0, 0, 0, 8'h00));
    push_req(make_req(REQ_READ, 0, 0, LETTERS - 1, 8'h00));
    push_req(make_req(REQ_READ, 31, 0, 31, 8'hFF));
    // Longest rotation, then a read that wraps around the ring.
    push_req(make_req(REQ_ALIGN, 0, 0, 0, 8'hFF));
    push_req(make_req(REQ_READ, 0, 0, 0, 8'h00));
    push_req(make_req(REQ_READ, 0, 0, 1, 8'h00));
    push_req(make_req(REQ_ALIGN, 0, 0, 0, 8'h00));
    // A letter that is not on the wheel leaves it unrotated.
    push_req(make_req(REQ_ALIGN, 31, 0, 31, 8'hAA));
    push_req(make_req(REQ_ALIGN, 0, 0, 0, 8'h00));
    push_req(make_req(REQ_SET, 31, 31, 31, 8'hFF));
    push_req(make_req(REQ_READ, 0, 31, 0, 8'h00));
    push_req(make_req(REQ_ALIGN, 0, 31, 0, 8'h5A));
    // Setting the slot again clears its offset.
    push_req(make_req(REQ_SET, 1, 0, 0, 8'h00));
    push_req(make_req(REQ_READ, 0, 0, 0, 8'h00));

    repeat (9) @(negedge clk);
    rst <= 1'b0;
    wait_drained();

    // Random part: mostly aligns and reads on loaded wheels, some noise.
    start = items_queued;
    while (items_queued - start < RANDOM_ITEMS) begin
      if (!paused && items_queued - start > RANDOM_ITEMS / 2) begin
        wait_drained();
        paused = 1'b1;
      end
      sel = $urandom_range(0, 99);
      if (sel < 8) begin
        // Whole wheel, either wide bytes or a narrow alphabet with repeats.
        s = INDEX_W'($urandom_range(0, WHEELS - 1));
        narrow = $urandom_range(0, 1);
        for (int p = 0; p < LETTERS; p++) begin
          ltr = narrow ? 8'h41 + LETTER_W'($urandom_range(0, 5))
                       : LETTER_W'($urandom_range(0, 255));
          push_req(make_req(REQ_LOAD, int'(s), $urandom_range(0, 31), p, int'(ltr)));
        end
      end else if (sel < 16) begin
        s = INDEX_W'($urandom_range(0, 31));
        push_req(make_req(REQ_SET, $urandom_range(0, WHEELS - 1), int'(s),
                          $urandom_range(0, 31), $urandom_range(0, 255)));
        for (int k = 0; k < 2; k++)
          push_req(make_req(REQ_ALIGN, $urandom_range(0, 31), int'(s), $urandom_range(0, 31),
                            int'(pick_align_letter(s))));
      end else if (sel < 66) begin
        s = INDEX_W'($urandom_range(0, 31));
        push_req(make_req(REQ_ALIGN, $urandom_range(0, 31), int'(s), $urandom_range(0, 31),
                          int'(pick_align_letter(s))));
        if ($urandom_range(0, 1))
          push_req(make_req(REQ_READ, $urandom_range(0, 31), int'(s),
                            $urandom_range(0, LETTERS - 1), $urandom_range(0, 255)));
      end else if (sel < 80) begin
        push_req(make_req(REQ_READ, $urandom_range(0, 31), $urandom_range(0, 31),
                          $urandom_range(0, 31), $urandom_range(0, 255)));
      end else if (sel < 90) begin
        push_req(make_req(REQ_LOAD, $urandom_range(0, 31), $urandom_range(0, 31),
                          $urandom_range(0, 31), $urandom_range(0, 255)));
      end else begin
        push_req(random_req());
      end
    end

    wait_drained();
    repeat (LETTERS + 8) @(posedge clk);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
